### src/rad_pkg.sv
// Shared constants for the restoring array divider.
package rad_pkg;

   // default core width: quotient, remainder and divisor bits
   localparam int unsigned CORE_BITS_DEF = 16;

endpackage

### src/rad_cell.sv
// One divider array row: shift, compare, conditional subtract, plus its pipeline register.
module rad_cell #(
   parameter int unsigned CORE_BITS = rad_pkg::CORE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  logic [CORE_BITS-1:0] up_rem,
   input  logic [CORE_BITS-1:0] up_low,
   input  logic [CORE_BITS-1:0] up_quo,
   input  logic [CORE_BITS-1:0] up_dvs,
   output logic                 down_valid,
   input  logic                 down_ready,
   output logic [CORE_BITS-1:0] down_rem,
   output logic [CORE_BITS-1:0] down_low,
   output logic [CORE_BITS-1:0] down_quo,
   output logic [CORE_BITS-1:0] down_dvs
);

   logic                 valid_ff, valid_in;
   logic [CORE_BITS-1:0] rem_ff, rem_in;
   logic [CORE_BITS-1:0] low_ff, low_in;
   logic [CORE_BITS-1:0] quo_ff, quo_in;
   logic [CORE_BITS-1:0] dvs_ff;
   logic [CORE_BITS:0]   wide;
   logic [CORE_BITS-1:0] diff;
   logic                 take;
   logic                 load;

   // register is free when empty or when its content moves on this cycle
   assign up_ready = !valid_ff || down_ready;
   assign load     = up_valid && up_ready;

   always_comb begin
      wide     = {up_rem, up_low[CORE_BITS-1]};
      // only the low bits of the difference are kept
      diff     = wide[CORE_BITS-1:0] - up_dvs;
      take     = wide >= {1'b0, up_dvs};
      rem_in   = take ? diff : wide[CORE_BITS-1:0];
      low_in   = {up_low[CORE_BITS-2:0], 1'b0};
      quo_in   = {up_quo[CORE_BITS-2:0], take};
      valid_in = up_valid || (valid_ff && !down_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
         quo_ff <= quo_in;
         dvs_ff <= up_dvs;
      end
   end

   assign down_valid = valid_ff;
   assign down_rem   = rem_ff;
   assign down_low   = low_ff;
   assign down_quo   = quo_ff;
   assign down_dvs   = dvs_ff;

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock) reset |=> !valid_ff)
      else $error("row register not empty after reset");

   a_load_fills: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("accepted transaction lost in row");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !down_ready |=> valid_ff && $stable(rem_ff) && $stable(quo_ff))
      else $error("stalled row changed its contents");
`endif

endmodule

### src/restoring_array_divider.sv
// Restoring array divider: CORE_BITS rows, one pipeline register per row.
// Each request passes through every row register, row 0 first, before rsp_valid rises.
// Throughput: one transaction per cycle while rsp_ready stays high; each row register fills as soon as it frees up.
// Backpressure ripples through the row ready chain, so bubbles are squeezed out.
// Reset (synchronous, active high) clears every row's valid bit; data is not reset.
module restoring_array_divider #(
   parameter int unsigned CORE_BITS = rad_pkg::CORE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2*CORE_BITS-2:0] req_dividend,
   input  logic [CORE_BITS-1:0]   req_divisor,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CORE_BITS-1:0]   rsp_quotient,
   output logic [CORE_BITS-1:0]   rsp_remainder
);

   import rad_pkg::*;

   logic                 valid_s [0:CORE_BITS];
   logic                 ready_s [0:CORE_BITS];
   logic [CORE_BITS-1:0] rem_s   [0:CORE_BITS];
   logic [CORE_BITS-1:0] low_s   [0:CORE_BITS];
   logic [CORE_BITS-1:0] quo_s   [0:CORE_BITS];
   logic [CORE_BITS-1:0] dvs_s   [0:CORE_BITS];

   // row 0 sees the top CORE_BITS-1 dividend bits with a zero above them
   assign valid_s[0] = req_valid;
   assign req_ready  = ready_s[0];
   assign rem_s[0]   = {1'b0, req_dividend[2*CORE_BITS-2:CORE_BITS]};
   assign low_s[0]   = req_dividend[CORE_BITS-1:0];
   assign quo_s[0]   = '0;
   assign dvs_s[0]   = req_divisor;

   for (genvar r = 0; r < CORE_BITS; r++) begin : g_row
      rad_cell #(
         .CORE_BITS (CORE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (valid_s[r]),
         .up_ready   (ready_s[r]),
         .up_rem     (rem_s[r]),
         .up_low     (low_s[r]),
         .up_quo     (quo_s[r]),
         .up_dvs     (dvs_s[r]),
         .down_valid (valid_s[r+1]),
         .down_ready (ready_s[r+1]),
         .down_rem   (rem_s[r+1]),
         .down_low   (low_s[r+1]),
         .down_quo   (quo_s[r+1]),
         .down_dvs   (dvs_s[r+1])
      );
   end

   assign ready_s[CORE_BITS] = rsp_ready;
   assign rsp_valid          = valid_s[CORE_BITS];
   assign rsp_quotient       = quo_s[CORE_BITS];
   assign rsp_remainder      = rem_s[CORE_BITS];

endmodule

### dv/tb_top.sv
// Testbench for restoring_array_divider: directed and random divisions checked by a predictor.
module tb_top;
   import rad_pkg::*;

   localparam int N     = rad_pkg::CORE_BITS_DEF;
   localparam int DVD_W = 2 * N - 1;

   typedef struct packed {
      logic [N-1:0] quotient;
      logic [N-1:0] remainder;
   } div_result_type;

   logic             clock         = 1'b0;
   logic             reset         = 1'b1;
   logic             req_valid     = 1'b0;
   logic             req_ready;
   logic [DVD_W-1:0] req_dividend  = '0;
   logic [N-1:0]     req_divisor   = '0;
   logic             rsp_valid;
   logic             rsp_ready     = 1'b0;
   logic [N-1:0]     rsp_quotient;
   logic [N-1:0]     rsp_remainder;

   div_result_type pending_divs[$];
   int             err_cnt    = 0;
   int             gap_max    = 0;
   int             burst_left = 0;
   bit             rsp_always = 1'b0;
   int             stall_pct  = 0;
   int             stall_left = 0;

   restoring_array_divider #(.CORE_BITS(N)) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_dividend  (req_dividend),
      .req_divisor   (req_divisor),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_quotient  (rsp_quotient),
      .rsp_remainder (rsp_remainder)
   );

   always #1 clock = ~clock;

   // One compare/subtract row per quotient bit, MSB first.
   function automatic div_result_type divide_rows(input logic [DVD_W-1:0] dvd,
                                                  input logic [N-1:0] dvs);
      logic [N-1:0]   part;
      logic [N:0]     wide;
      div_result_type res;
      res.quotient = '0;
      part = dvd[DVD_W-1 -: N];
      if (part >= dvs) begin
         part = part - dvs;
         res.quotient[N-1] = 1'b1;
      end
      for (int row = 1; row < N; row++) begin
         wide = {part, dvd[N-1-row]};
         if (wide >= {1'b0, dvs}) begin
            wide = wide - {1'b0, dvs};
            res.quotient[N-1-row] = 1'b1;
         end
         part = wide[N-1:0];
      end
      res.remainder = part;
      return res;
   endfunction

   task automatic note_error(input string msg);
      if (err_cnt < 10)
         $display("ERROR @%0t: %s", $time, msg);
      err_cnt++;
   endtask

   // Predict on request acceptance, compare on response acceptance.
   always @(posedge clock) begin
      div_result_type exp_res;
      if (!reset) begin
         if (req_valid && req_ready)
            pending_divs.push_back(divide_rows(req_dividend, req_divisor));
         if (rsp_valid && rsp_ready) begin
            if (pending_divs.size() == 0) begin
               note_error($sformatf("unexpected result q=%h r=%h", rsp_quotient, rsp_remainder));
            end else begin
               exp_res = pending_divs.pop_front();
               if (rsp_quotient !== exp_res.quotient)
                  note_error($sformatf("quotient exp %h got %h",
                                       exp_res.quotient, rsp_quotient));
               if (rsp_remainder !== exp_res.remainder)
                  note_error($sformatf("remainder exp %h got %h",
                                       exp_res.remainder, rsp_remainder));
            end
         end
      end
   end

   // Receiver: stall probability is redrawn whenever its random hold counter runs out.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         case ($urandom_range(3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 85;
         endcase
         stall_left = $urandom_range(80, 10);
      end
      stall_left--;
      rsp_ready <= rsp_always || ($urandom_range(99) >= stall_pct);
   end

   // Called at a clock edge; returns at the edge where the transaction is accepted
   // (or after the following gap).
   task automatic send_div(input logic [DVD_W-1:0] dvd, input logic [N-1:0] dvs);
      req_valid    <= 1'b1;
      req_dividend <= dvd;
      req_divisor  <= dvs;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(24, 1);
         if (gap_max > 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(gap_max, 1)) @(posedge clock);
         end
      end
   endtask

   // Random division whose quotient fits N bits.
   task automatic send_exact_div();
      logic [N-1:0]    dvs;
      longint unsigned q_top;
      longint unsigned quo;
      longint unsigned rem;
      dvs = N'($urandom());
      dvs = dvs >> $urandom_range(N - 1, 0);
      if (dvs == '0)
         dvs = N'(1);
      q_top = ((64'd1 << DVD_W) - dvs) / dvs;
      if (q_top > (64'd1 << N) - 1)
         q_top = (64'd1 << N) - 1;
      quo = $urandom_range(32'(q_top), 0);
      rem = $urandom_range(dvs - 1, 0);
      send_div(DVD_W'(quo * dvs + rem), dvs);
   endtask

   task automatic test_directed();
      logic [DVD_W-1:0] dmax;
      dmax    = '1;
      gap_max = 2;
      send_div('0, '0);
      send_div(dmax, '0);
      send_div(31'h2AAA_AAAA, '0);
      send_div(dmax, 16'd1);
      send_div(dmax, 16'hFFFF);
      send_div('0, 16'd1);
      send_div('0, 16'hFFFF);
      send_div(31'd1, 16'hFFFF);
      send_div(31'h7FFF_8000, 16'hFFFF);   // top bits equal divisor
      send_div(31'h7FFF_7FFF, 16'hFFFF);   // top bits one below divisor
      send_div(31'd8370587, 16'd678);
      send_div(31'd100, 16'd7);
      send_div(31'h5555_5555, 16'h5555);
      send_div(31'h4000_0000, 16'h8000);
      send_div(31'h3FFF_FFFF, 16'h8000);
      send_div(31'h0000_8000, 16'd1);
      send_div(dmax, 16'h8000);
      send_div(31'd65535, 16'd65535);
      send_div(31'h7FFF_0000, 16'd3);      // quotient overflow
   endtask

   task automatic test_exact_divisions(input int count);
      gap_max = 5;
      repeat (count) send_exact_div();
   endtask

   // Overflow, zero divisor and unconstrained operands mixed together.
   task automatic test_random_mix(input int count);
      logic [DVD_W-1:0] dvd;
      logic [N-1:0]     dvs;
      gap_max = 3;
      repeat (count) begin
         dvd = DVD_W'($urandom());
         dvs = N'($urandom());
         case ($urandom_range(5))
            0: dvs = '0;
            1: dvs = N'($urandom_range(3, 1));
            2: dvd = dvd >> $urandom_range(DVD_W - 1, 0);
            3: dvs = N'(dvd[DVD_W-1 -: N] + $urandom_range(2, 0) - 1);
            default: ;
         endcase
         send_div(dvd, dvs);
      end
   endtask

   task automatic test_streaming(input int count);
      gap_max    = 0;
      rsp_always = 1'b1;
      repeat (count) send_exact_div();
      rsp_always = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_exact_divisions(500);
      test_random_mix(400);
      test_streaming(200);
      req_valid <= 1'b0;
      for (int c = 0; c < 100000 && pending_divs.size() != 0; c++)
         @(posedge clock);
      repeat (2 * N + 8) @(posedge clock);
      if (err_cnt == 0 && pending_divs.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #500000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
